@@ rtl/sfd_pkg.sv @@
// Shared types and constants for the SLIP frame decoder.
package sfd_pkg;

    localparam int          DEFAULT_LEN_WIDTH = 16;
    localparam int          MAX_LEN_WIDTH     = 16;
    localparam logic [15:0] MAX_LEN_RESET     = 16'd1024;

    localparam logic [7:0] SYM_END     = 8'hC0;
    localparam logic [7:0] SYM_ESC     = 8'hDB;
    localparam logic [7:0] SYM_ESC_END = 8'hDC;
    localparam logic [7:0] SYM_ESC_ESC = 8'hDD;

    typedef enum logic [3:0] {
        MODE_NEW   = 4'b0001,
        MODE_FLUSH = 4'b0010,
        MODE_OPEN  = 4'b0100,
        MODE_ESC   = 4'b1000
    } mode_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ABORT = 2'd2
    } kind_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  data;
        logic [15:0] length;
    } result_t;

endpackage

@@ rtl/sfd_step.sv @@
// Per-byte decode step: next mode, next count and the result of one byte.
module sfd_step #(
    parameter int LEN_WIDTH = sfd_pkg::DEFAULT_LEN_WIDTH
) (
    input  sfd_pkg::mode_t      mode,
    input  logic [LEN_WIDTH-1:0] count,
    input  logic [7:0]           rx_byte,
    input  logic [15:0]          max_len,
    output sfd_pkg::mode_t      mode_next,
    output logic [LEN_WIDTH-1:0] count_next,
    output sfd_pkg::result_t    result
);

    localparam int CMP_W = (LEN_WIDTH > sfd_pkg::MAX_LEN_WIDTH) ?
                           LEN_WIDTH : sfd_pkg::MAX_LEN_WIDTH;

    logic [CMP_W-1:0] count_w;
    logic [CMP_W-1:0] max_w;
    logic             overrun;
    logic [7:0]       push_data;
    logic [15:0]      length_out;

    assign count_w    = CMP_W'(count);
    assign max_w      = CMP_W'(max_len);
    assign overrun    = (count_w >= max_w) || (&count);
    assign length_out = count_w[15:0];

    always_comb begin
        mode_next      = mode;
        count_next     = count;
        result         = '0;
        result.kind    = sfd_pkg::KIND_DATA;
        push_data      = rx_byte;

        case (mode)
            sfd_pkg::MODE_NEW: begin
                mode_next  = (rx_byte == sfd_pkg::SYM_END) ? sfd_pkg::MODE_OPEN
                                                           : sfd_pkg::MODE_FLUSH;
                count_next = '0;
            end
            sfd_pkg::MODE_FLUSH: begin
                if (rx_byte == sfd_pkg::SYM_END) begin
                    mode_next = sfd_pkg::MODE_NEW;
                end
            end
            sfd_pkg::MODE_OPEN: begin
                if (rx_byte == sfd_pkg::SYM_END) begin
                    result.valid  = 1'b1;
                    result.kind   = sfd_pkg::KIND_END;
                    result.length = length_out;
                    count_next    = '0;
                    mode_next     = sfd_pkg::MODE_NEW;
                end else if (rx_byte == sfd_pkg::SYM_ESC) begin
                    mode_next = sfd_pkg::MODE_ESC;
                end else begin
                    result.valid = 1'b1;
                    if (overrun) begin
                        result.kind = sfd_pkg::KIND_ABORT;
                        mode_next   = sfd_pkg::MODE_NEW;
                    end else begin
                        result.data = rx_byte;
                        count_next  = count + LEN_WIDTH'(1);
                    end
                end
            end
            sfd_pkg::MODE_ESC: begin
                result.valid = 1'b1;
                if ((rx_byte == sfd_pkg::SYM_ESC_END) ||
                    (rx_byte == sfd_pkg::SYM_ESC_ESC)) begin
                    push_data = (rx_byte == sfd_pkg::SYM_ESC_END) ? sfd_pkg::SYM_END
                                                                  : sfd_pkg::SYM_ESC;
                    if (overrun) begin
                        result.kind = sfd_pkg::KIND_ABORT;
                        mode_next   = sfd_pkg::MODE_NEW;
                    end else begin
                        result.data = push_data;
                        count_next  = count + LEN_WIDTH'(1);
                        mode_next   = sfd_pkg::MODE_OPEN;
                    end
                end else begin
                    // bad escape: abort, then treat the byte as a possible opening boundary
                    result.kind = sfd_pkg::KIND_ABORT;
                    mode_next   = (rx_byte == sfd_pkg::SYM_END) ? sfd_pkg::MODE_OPEN
                                                                : sfd_pkg::MODE_FLUSH;
                    count_next  = '0;
                end
            end
            default: begin
                mode_next  = sfd_pkg::MODE_NEW;
                count_next = '0;
            end
        endcase
    end

endmodule

@@ rtl/sfd_result_reg.sv @@
// Result register with valid/ready toward the consumer.
module sfd_result_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  sfd_pkg::result_t result,
    output logic             free,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_out_kind,
    output logic [7:0]       m_out_byte,
    output logic [15:0]      m_frame_length
);

    logic             valid_reg;
    logic             valid_next;
    sfd_pkg::result_t data_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg && !m_ready;
        if (load) begin
            valid_next = result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && result.valid) begin
            data_reg <= result;
        end
    end

    assign m_valid        = valid_reg;
    assign m_out_kind     = data_reg.kind;
    assign m_out_byte     = data_reg.data;
    assign m_frame_length = data_reg.length;

endmodule

@@ rtl/slip_frame_decoder.sv @@
// SLIP frame decoder top level: input register, decode step, result register.
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  input   | s_valid, s_ready, s_rx_byte[7:0]               | in
//  result  | m_valid, m_ready, m_out_kind[1:0],             | out
//          | m_out_byte[7:0], m_frame_length[15:0]          |
//  config  | cfg_valid, cfg_ready, cfg_wdata[15:0] (max_len)| in
//
// One byte per cycle unless the result stalls; the result register offers each result.
// The decode step runs from the input register into the result register.
// A stalled result holds the input register, whether or not that byte has a result.
// Reset is synchronous, active low; max_len resets to 1024, config always ready.
module slip_frame_decoder #(
    parameter int LEN_WIDTH = sfd_pkg::DEFAULT_LEN_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_out_kind,
    output logic [7:0]  m_out_byte,
    output logic [15:0] m_frame_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_wdata
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [7:0]           in_byte_reg;
    logic [15:0]          max_len_reg;
    sfd_pkg::mode_t       mode_reg;
    sfd_pkg::mode_t       mode_next;
    logic [LEN_WIDTH-1:0] count_reg;
    logic [LEN_WIDTH-1:0] count_next;
    sfd_pkg::result_t     step_result;
    logic                 out_free;
    logic                 advance;

    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg && !advance;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            mode_reg     <= sfd_pkg::MODE_NEW;
            count_reg    <= '0;
            max_len_reg  <= sfd_pkg::MAX_LEN_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            if (advance) begin
                mode_reg  <= mode_next;
                count_reg <= count_next;
            end
            if (cfg_valid && cfg_ready) begin
                max_len_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    sfd_step #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_step (
        .mode       (mode_reg),
        .count      (count_reg),
        .rx_byte    (in_byte_reg),
        .max_len    (max_len_reg),
        .mode_next  (mode_next),
        .count_next (count_next),
        .result     (step_result)
    );

    sfd_result_reg u_result (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (advance),
        .result         (step_result),
        .free           (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_kind     (m_out_kind),
        .m_out_byte     (m_out_byte),
        .m_frame_length (m_frame_length)
    );

    a_end_returns_new: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && step_result.valid && step_result.kind == sfd_pkg::KIND_END)
        |=> (mode_reg == sfd_pkg::MODE_NEW && count_reg == '0))
    else $error("frame end did not return to expecting a boundary");

    a_byte_only_on_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_kind != sfd_pkg::KIND_DATA) |-> (m_out_byte == 8'd0))
    else $error("non-data result carries a byte");

    a_abort_no_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_kind != sfd_pkg::KIND_END) |-> (m_frame_length == 16'd0))
    else $error("length reported outside frame end");

    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> ($stable(mode_reg) && $stable(count_reg)))
    else $error("decode state moved while result stalled");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the SLIP frame decoder: byte stream in, decoded items out.
`timescale 1ns / 1ps

module tb_top;

    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_out_kind;
    logic [7:0]  m_out_byte;
    logic [15:0] m_frame_length;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_wdata = 16'd0;

    // bytes waiting to go out on the line, and decoded items still owed by the block
    logic [7:0]       line_q[$];
    sfd_pkg::result_t decoded_q[$];

    // predictor state
    sfd_pkg::mode_t dec_mode = sfd_pkg::MODE_NEW;
    logic [15:0]    dec_count = '0;
    logic [15:0]    len_limit = sfd_pkg::MAX_LEN_RESET;

    logic        byte_taken = 1'b0;
    logic        idle_on = 1'b1;
    int          send_gap = 0;
    int          rcv_gap = 0;
    int          hold_cycles = 0;
    int          cycle_count = 0;
    int          errors = 0;
    int          bytes_in = 0;
    int          n_data = 0;
    int          n_end = 0;
    int          n_abort = 0;
    int          queued = 0;
    logic [15:0] mid_limit;

    slip_frame_decoder dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_kind     (m_out_kind),
        .m_out_byte     (m_out_byte),
        .m_frame_length (m_frame_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_wdata      (cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Enter the expecting-boundary handling for one byte.
    function automatic void rearm(input logic [7:0] rx);
        dec_count = '0;
        if (rx == sfd_pkg::SYM_END) begin
            dec_mode = sfd_pkg::MODE_OPEN;
        end else begin
            dec_mode = sfd_pkg::MODE_FLUSH;
        end
    endfunction

    function automatic sfd_pkg::result_t store_byte(input logic [7:0] b);
        sfd_pkg::result_t res;
        res = '0;
        res.valid = 1'b1;
        if (dec_count >= len_limit || dec_count == '1) begin
            dec_mode = sfd_pkg::MODE_NEW;
            res.kind = sfd_pkg::KIND_ABORT;
        end else begin
            dec_count = dec_count + 16'd1;
            dec_mode = sfd_pkg::MODE_OPEN;
            res.kind = sfd_pkg::KIND_DATA;
            res.data = b;
        end
        return res;
    endfunction

    function automatic void decode_byte(input logic [7:0] rx, output bit got,
                                        output sfd_pkg::result_t res);
        got = 1'b0;
        res = '0;
        res.valid = 1'b1;
        case (dec_mode)
            sfd_pkg::MODE_NEW: begin
                rearm(rx);
            end
            sfd_pkg::MODE_FLUSH: begin
                if (rx == sfd_pkg::SYM_END) dec_mode = sfd_pkg::MODE_NEW;
            end
            sfd_pkg::MODE_OPEN: begin
                if (rx == sfd_pkg::SYM_END) begin
                    got = 1'b1;
                    res.kind = sfd_pkg::KIND_END;
                    res.length = dec_count;
                    dec_count = '0;
                    dec_mode = sfd_pkg::MODE_NEW;
                end else if (rx == sfd_pkg::SYM_ESC) begin
                    dec_mode = sfd_pkg::MODE_ESC;
                end else begin
                    got = 1'b1;
                    res = store_byte(rx);
                end
            end
            sfd_pkg::MODE_ESC: begin
                got = 1'b1;
                if (rx == sfd_pkg::SYM_ESC_END) begin
                    res = store_byte(sfd_pkg::SYM_END);
                end else if (rx == sfd_pkg::SYM_ESC_ESC) begin
                    res = store_byte(sfd_pkg::SYM_ESC);
                end else begin
                    // bad escape: abort, then treat the byte as a possible opening boundary
                    res.kind = sfd_pkg::KIND_ABORT;
                    rearm(rx);
                end
            end
            default: begin
                dec_mode = sfd_pkg::MODE_NEW;
            end
        endcase
    endfunction

    // Sender: present the next byte once the current one is taken.
    always @(negedge aclk) begin
        if (!s_valid || byte_taken) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (line_q.size() > 0) begin
                s_valid <= 1'b1;
                s_rx_byte <= line_q.pop_front();
                if (idle_on && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 5);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: a long hold-off when one is set, otherwise short random stalls.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            m_ready <= 1'b0;
        end else if (rcv_gap > 0) begin
            rcv_gap = rcv_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0) rcv_gap = $urandom_range(1, 5);
        end
    end

    // Monitor: predict on each accepted byte, check each accepted item.
    always @(posedge aclk) begin
        bit               got;
        sfd_pkg::result_t res;
        sfd_pkg::result_t want;
        byte_taken <= aresetn && s_valid && s_ready;
        if (!aresetn) begin
            dec_mode = sfd_pkg::MODE_NEW;
            dec_count = '0;
            len_limit = sfd_pkg::MAX_LEN_RESET;
        end else begin
            if (cfg_valid && cfg_ready) len_limit = cfg_wdata;
            if (s_valid && s_ready) begin
                bytes_in++;
                decode_byte(s_rx_byte, got, res);
                if (got) decoded_q.push_back(res);
            end
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected item kind=%0d byte=%h length=%0d", $time,
                             m_out_kind, m_out_byte, m_frame_length);
                    errors++;
                end else begin
                    want = decoded_q.pop_front();
                    case (want.kind)
                        sfd_pkg::KIND_DATA: n_data++;
                        sfd_pkg::KIND_END:  n_end++;
                        default:            n_abort++;
                    endcase
                    if (m_out_kind !== want.kind) begin
                        $display("%0t: kind expected %0d, got %0d", $time, want.kind,
                                 m_out_kind);
                        errors++;
                    end
                    if (m_out_byte !== want.data) begin
                        $display("%0t: byte expected %h, got %h", $time, want.data,
                                 m_out_byte);
                        errors++;
                    end
                    if (m_frame_length !== want.length) begin
                        $display("%0t: length expected %0d, got %0d", $time, want.length,
                                 m_frame_length);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d items outstanding", $time, decoded_q.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        line_q.push_back(b);
        queued++;
    endtask

    task automatic wait_drained();
        while (line_q.size() != 0 || s_valid || byte_taken || decoded_q.size() != 0)
            @(posedge aclk);
        // bytes without an item may still be in the pipeline
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_len(input logic [15:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // One chunk of line traffic: mostly clean frames, some noise and broken frames.
    task automatic add_random_chunk(input int cap);
        int          pick;
        int          n;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            n = $urandom_range(0, cap);
            queue_byte(sfd_pkg::SYM_END);
            repeat (n) begin
                if ($urandom_range(0, 5) == 0) begin
                    b = $urandom_range(0, 1) ? sfd_pkg::SYM_END : sfd_pkg::SYM_ESC;
                end else begin
                    b = 8'($urandom);
                end
                if (b == sfd_pkg::SYM_END) begin
                    queue_byte(sfd_pkg::SYM_ESC);
                    queue_byte(sfd_pkg::SYM_ESC_END);
                end else if (b == sfd_pkg::SYM_ESC) begin
                    queue_byte(sfd_pkg::SYM_ESC);
                    queue_byte(sfd_pkg::SYM_ESC_ESC);
                end else begin
                    queue_byte(b);
                end
            end
            queue_byte(sfd_pkg::SYM_END);
        end else if (pick < 85) begin
            repeat ($urandom_range(1, 6)) queue_byte(8'($urandom));
            queue_byte(sfd_pkg::SYM_END);
        end else begin
            queue_byte(sfd_pkg::SYM_END);
            repeat ($urandom_range(0, 3)) queue_byte(8'($urandom));
            queue_byte(sfd_pkg::SYM_ESC);
            if ($urandom_range(0, 1)) begin
                b = sfd_pkg::SYM_END;
            end else begin
                do b = 8'($urandom);
                while (b == sfd_pkg::SYM_ESC_END || b == sfd_pkg::SYM_ESC_ESC);
            end
            queue_byte(b);
            queue_byte(sfd_pkg::SYM_END);
        end
    endtask

    task automatic run_random(input int count, input int cap);
        queued = 0;
        while (queued < count) add_random_chunk(cap);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(posedge aclk);

        // reset limit: flush, escapes, empty frame, bad escapes
        begin
            logic [7:0] seq[$];
            seq = {8'h55, 8'h00, sfd_pkg::SYM_END, sfd_pkg::SYM_END, 8'h00, 8'hFF,
                   sfd_pkg::SYM_ESC, sfd_pkg::SYM_ESC_END,
                   sfd_pkg::SYM_ESC, sfd_pkg::SYM_ESC_ESC,
                   sfd_pkg::SYM_END, sfd_pkg::SYM_END, sfd_pkg::SYM_END,
                   sfd_pkg::SYM_END, sfd_pkg::SYM_ESC, 8'h41, sfd_pkg::SYM_END,
                   sfd_pkg::SYM_END, sfd_pkg::SYM_ESC, sfd_pkg::SYM_END, 8'h7E,
                   sfd_pkg::SYM_END,
                   sfd_pkg::SYM_END, sfd_pkg::SYM_ESC, sfd_pkg::SYM_ESC, sfd_pkg::SYM_END};
            foreach (seq[i]) queue_byte(seq[i]);
            wait_drained();

            // limit of one: plain and escaped overrun
            write_max_len(16'd1);
            seq = {sfd_pkg::SYM_END, 8'h11, 8'h22, 8'h33, sfd_pkg::SYM_END,
                   sfd_pkg::SYM_END, sfd_pkg::SYM_ESC, sfd_pkg::SYM_ESC_END,
                   sfd_pkg::SYM_ESC, sfd_pkg::SYM_ESC_ESC,
                   sfd_pkg::SYM_END, sfd_pkg::SYM_END};
            foreach (seq[i]) queue_byte(seq[i]);
            wait_drained();
        end

        // largest limit, with a long result stall while bytes keep coming
        write_max_len(16'hFFFF);
        run_random(150, 24);
        @(posedge aclk);
        hold_cycles = 60;
        wait_drained();

        write_max_len(16'd5);
        run_random(180, 8);
        wait_drained();

        mid_limit = 16'($urandom_range(1, 40));
        write_max_len(mid_limit);
        run_random(150, (mid_limit + 3 > 40) ? 40 : int'(mid_limit) + 3);
        wait_drained();

        // closing stretch at full rate
        idle_on = 1'b0;
        write_max_len(16'd16);
        run_random(110, 20);
        wait_drained();

        $display("covered %0d line bytes: %0d data, %0d frame ends, %0d aborts", bytes_in,
                 n_data, n_end, n_abort);
        $display("max_len settings 1024, 1, 65535, 5, %0d, 16; %0d mismatches", mid_limit,
                 errors);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/sfd_pkg.sv
rtl/sfd_step.sv
rtl/sfd_result_reg.sv
rtl/slip_frame_decoder.sv
tb/tb_top.sv
